@@ sv/lda_pkg.sv @@
// Shared types and constants for the log-domain audio compressor.
// Holds the controller/datapath command and status structs and the exp2 root table.
// No dependencies.
package lda_pkg;

  typedef logic [30:0] root_tab_t [16];

  typedef struct packed {
    logic load;
    logic norm;
    logic level;
    logic target;
    logic env0;
    logic env1;
    logic env2;
    logic env3;
    logic expo;
    logic gain;
    logic shift;
    logic out;
  } cmd_t;

  typedef struct packed {
    logic norm_done;
    logic gain_done;
  } stat_t;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_RATIO     = 2'd1;
  localparam logic [1:0] REG_ATTACK    = 2'd2;
  localparam logic [1:0] REG_RELEASE   = 2'd3;

  function automatic logic [63:0] isqrt(logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = n;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Q1.30 values of 2^(2^-(k+1)), each the truncated square root of the previous one.
  function automatic root_tab_t build_roots();
    root_tab_t   t;
    logic [63:0] r;
    r = isqrt(64'd2 << 60);
    t[0] = r[30:0];
    for (int k = 1; k < 16; k++) begin
      r = isqrt(r << 30);
      t[k] = r[30:0];
    end
    return t;
  endfunction

  localparam root_tab_t ROOTS = build_roots();

endpackage

@@ sv/lda_ctrl.sv @@
// Sequencer for the log-domain audio compressor.
// Steps the datapath through one sample and owns both handshakes; uses lda_pkg.
module lda_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  lda_pkg::stat_t stat,
  output lda_pkg::cmd_t  cmd
);
  import lda_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_NORM   = 12'b000000000010,
    S_LEVEL  = 12'b000000000100,
    S_TARGET = 12'b000000001000,
    S_ENV0   = 12'b000000010000,
    S_ENV1   = 12'b000000100000,
    S_ENV2   = 12'b000001000000,
    S_ENV3   = 12'b000010000000,
    S_EXP    = 12'b000100000000,
    S_GAIN   = 12'b001000000000,
    S_SHIFT  = 12'b010000000000,
    S_OUT    = 12'b100000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_load;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign out_load = (state == S_OUT) && (!out_valid || m_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (s_tvalid) state_next = S_NORM;
      S_NORM:   if (stat.norm_done) state_next = S_LEVEL;
      S_LEVEL:  state_next = S_TARGET;
      S_TARGET: state_next = S_ENV0;
      S_ENV0:   state_next = S_ENV1;
      S_ENV1:   state_next = S_ENV2;
      S_ENV2:   state_next = S_ENV3;
      S_ENV3:   state_next = S_EXP;
      S_EXP:    state_next = S_GAIN;
      S_GAIN:   if (stat.gain_done) state_next = S_SHIFT;
      S_SHIFT:  state_next = S_OUT;
      S_OUT:    if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.load   = (state == S_IDLE) && s_tvalid;
    cmd.norm   = (state == S_NORM) && !stat.norm_done;
    cmd.level  = (state == S_LEVEL);
    cmd.target = (state == S_TARGET);
    cmd.env0   = (state == S_ENV0);
    cmd.env1   = (state == S_ENV1);
    cmd.env2   = (state == S_ENV2);
    cmd.env3   = (state == S_ENV3);
    cmd.expo   = (state == S_EXP);
    cmd.gain   = (state == S_GAIN);
    cmd.shift  = (state == S_SHIFT);
    cmd.out    = out_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/lda_dp.sv @@
// Datapath of the log-domain audio compressor: registers, tables and shared arithmetic.
// Driven by lda_ctrl through lda_pkg::cmd_t; uses lda_pkg for types and the root table.
module lda_dp #(
  parameter int SAMPLE_BITS    = 24,
  parameter int LOG_TABLE_BITS = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lda_pkg::cmd_t          cmd,
  output lda_pkg::stat_t         stat,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [24:0]            cfg_data,
  input  logic [SAMPLE_BITS-1:0] sample_in,
  output logic [SAMPLE_BITS-1:0] sample_out,
  output logic [24:0]            gain_db
);
  import lda_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int LTB = LOG_TABLE_BITS;
  localparam int PW  = $clog2(SB);

  typedef logic [15:0] log_tab_t [2**LTB];

  function automatic log_tab_t build_log();
    log_tab_t    t;
    logic [63:0] m;
    logic [15:0] f;
    for (int i = 0; i < 2**LTB; i++) begin
      m = (64'd1 << 30) + (64'(i) << (30 - LTB));
      f = '0;
      for (int k = 0; k < 16; k++) begin
        m = (m * m) >> 30;
        f = f << 1;
        if (m >= (64'd2 << 30)) begin
          f[0] = 1'b1;
          m = m >> 1;
        end
      end
      t[i] = f;
    end
    return t;
  endfunction

  localparam log_tab_t LOG_FRAC = build_log();

  logic signed [24:0] threshold;
  logic [16:0]        ratio;
  logic [24:0]        attack;
  logic [24:0]        release_c;

  logic signed [SB-1:0] x;
  logic [SB-1:0]        m;
  logic [PW-1:0]        p;
  logic                 zero;
  logic signed [27:0]   level;
  logic signed [27:0]   target;
  logic signed [36:0]   d;
  logic [24:0]          coef;
  logic [43:0]          plo;
  logic signed [43:0]   phi;
  logic signed [33:0]   env;
  logic [15:0]          f;
  logic [8:0]           shamt;
  logic [30:0]          g;
  logic [3:0]           k;

  logic [SB-1:0]        mag;
  logic signed [23:0]   l2;
  logic signed [43:0]   lprod;
  logic signed [27:0]   th28;
  logic signed [27:0]   diff;
  logic signed [45:0]   tprod;
  logic signed [35:0]   te;
  logic signed [36:0]   te37;
  logic signed [36:0]   env37;
  logic signed [63:0]   sum;
  logic signed [63:0]   envn;
  logic signed [56:0]   eprod;
  logic signed [24:0]   e;
  logic [61:0]          gprod;
  logic signed [SB+31:0] yprod;

  assign mag   = sample_in[SB-1] ? (~sample_in + 1'b1) : sample_in;
  assign l2    = ($signed({{(24-PW){1'b0}}, p}) - 24'(SB - 1)) * 24'sd65536
                 + $signed({8'd0, LOG_FRAC[m[SB-2 -: LTB]]});
  assign lprod = l2 * $signed(20'sd394566);
  assign th28  = 28'(threshold);
  assign diff  = th28 - level;
  assign tprod = diff * $signed({1'b0, ratio});
  assign te    = $signed({target, 8'd0});
  assign te37  = 37'(te);
  assign env37 = 37'(env);
  assign sum   = (64'(phi) <<< 19) + $signed({20'd0, plo});
  assign envn  = 64'(env) + (sum >>> 24);
  assign eprod = env * $signed(23'sd2786635);
  assign e     = eprod[56:32];
  assign gprod = g * ROOTS[k];
  assign yprod = x * $signed({1'b0, g});

  assign stat.norm_done = m[SB-1] || (p == '0) || zero;
  assign stat.gain_done = (k == 4'd15);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= -25'sd1310720;
      ratio     <= 17'd56174;
      attack    <= 25'd3804;
      release_c <= 25'd761;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: threshold <= $signed(cfg_data);
        REG_RATIO:     ratio     <= cfg_data[16:0];
        REG_ATTACK:    attack    <= cfg_data;
        REG_RELEASE:   release_c <= cfg_data;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      env <= '0;
    end else if (cmd.env3) begin
      if (envn > 64'sd0) begin
        env <= '0;
      end else if (envn < -64'sd4294967296) begin
        env <= -34'sd4294967296;
      end else begin
        env <= envn[33:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x    <= $signed(sample_in);
      m    <= mag;
      p    <= PW'(SB - 1);
      zero <= (sample_in == '0);
    end
    if (cmd.norm) begin
      m <= m << 1;
      p <= p - 1'b1;
    end
    if (cmd.level) begin
      level <= lprod[43:16];
    end
    if (cmd.target) begin
      target <= (!zero && (level > th28)) ? tprod[43:16] : '0;
    end
    if (cmd.env0) begin
      d    <= te37 - env37;
      coef <= (env37 > te37) ? attack : release_c;
    end
    if (cmd.env1) begin
      plo <= d[18:0] * coef;
    end
    if (cmd.env2) begin
      phi <= $signed(d[36:19]) * $signed({1'b0, coef});
    end
    if (cmd.expo) begin
      f     <= e[15:0];
      shamt <= 9'd0 - e[24:16];
      g     <= 31'd1 << 30;
      k     <= '0;
    end
    if (cmd.gain) begin
      if (f[15]) begin
        g <= gprod[60:30];
      end
      f <= f << 1;
      k <= k + 1'b1;
    end
    if (cmd.shift) begin
      g <= (shamt >= 9'd63) ? '0 : (g >> shamt[5:0]);
    end
    if (cmd.out) begin
      sample_out <= yprod[SB+29:30];
      gain_db    <= env[32:8];
    end
  end

endmodule

@@ sv/log_domain_audio_compressor.sv @@
// A sample is taken when the block is idle. Its result is presented after the leading-one
// search, whose length grows with the leading zeros of the sample magnitude; zero samples
// skip that search. A new sample is taken only once the previous result has been loaded into
// the result register. The leading-one search runs one bit a cycle, and the exp2 gain is
// formed one fraction bit at a time on one 31x31 multiplier. The result register lets the
// next sample enter while a result waits. Configuration writes take effect at once.
// Top level: joins lda_ctrl and lda_dp; uses lda_pkg.
module log_domain_audio_compressor #(
  parameter int SAMPLE_BITS    = 24,
  parameter int LOG_TABLE_BITS = 6
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // sample_in
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // sample_out, gain_db
  output logic [((SAMPLE_BITS+25+7)/8)*8-1:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [24:0] cfg_data
);
  import lda_pkg::*;

  localparam int IW = ((SAMPLE_BITS+7)/8)*8;
  localparam int OW = ((SAMPLE_BITS+25+7)/8)*8;

  cmd_t                   cmd;
  stat_t                  stat;
  logic [SAMPLE_BITS-1:0] sample_out;
  logic [24:0]            gain_db;

  lda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lda_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .LOG_TABLE_BITS (LOG_TABLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (s_tdata[SAMPLE_BITS-1:0]),
    .sample_out (sample_out),
    .gain_db    (gain_db)
  );

  assign m_tdata = OW'({gain_db, sample_out});

  a_gain_not_positive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (gain_db[24] || gain_db == 25'd0))
    else $error("gain above unity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second request accepted while busy");

  a_load_on_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (s_tvalid && s_tready))
    else $error("sample loaded without a request");

  a_input_width: assert property (@(posedge clk) disable iff (rst)
    cmd.out |-> !cmd.load && (IW >= SAMPLE_BITS))
    else $error("result and new sample in the same cycle");

endmodule

@@ test/testbench.sv @@
// Testbench for log_domain_audio_compressor: drives samples on the stream input, random stalls on
// both sides, and register writes between phases; checks every result against a predictor.
// Depends on lda_pkg for the register indexes.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lda_pkg::*;

  class gain_scoreboard;
    typedef struct {
      logic [23:0] sample_out;
      logic [24:0] gain_db;
    } result_t;

    result_t pending[$];
    int fails;
    longint threshold, ratio, attack, release_c, envelope;
    longint log_frac[64];
    longint unsigned roots[16];

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function new();
      longint unsigned m;
      longint f;
      for (int i = 0; i < 64; i++) begin
        m = 64'd1073741824 + (longint'(i) << 24);
        f = 0;
        for (int k = 0; k < 16; k++) begin
          m = (m * m) >> 30;
          f = f << 1;
          if (m >= 64'd2147483648) begin
            f = f | 1;
            m = m >> 1;
          end
        end
        log_frac[i] = f;
      end
      roots[0] = int_sqrt(64'd2 << 60);
      for (int k = 1; k < 16; k++) roots[k] = int_sqrt(roots[k-1] << 30);
      threshold = -1310720;
      ratio = 56174;
      attack = 3804;
      release_c = 761;
      envelope = 0;
      fails = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [24:0] value);
      case (idx)
        REG_THRESHOLD: threshold = longint'($signed(value));
        REG_RATIO:     ratio = longint'(value[16:0]);
        REG_ATTACK:    attack = longint'(value);
        REG_RELEASE:   release_c = longint'(value);
        default: ;
      endcase
    endfunction

    function void note_sample(logic [23:0] raw);
      longint x, mag, level, target, te, coef, e, q, f, l2, y;
      longint unsigned g;
      int p, idx;
      result_t r;
      x = longint'($signed(raw));
      mag = x < 0 ? -x : x;
      target = 0;
      if (mag != 0) begin
        p = 23;
        while (p > 0 && !mag[p]) p--;
        if (p >= 6) idx = int'((mag >> (p - 6)) & 63);
        else idx = int'((mag << (6 - p)) & 63);
        l2 = longint'(p - 23) * 65536 + log_frac[idx];
        level = (l2 * 394566) >>> 16;
        if (level > threshold) target = ((threshold - level) * ratio) >>> 16;
      end
      te = target * 256;
      coef = envelope > te ? attack : release_c;
      envelope = envelope + (((te - envelope) * coef) >>> 24);
      if (envelope > 0) envelope = 0;
      if (envelope < -64'sd4294967296) envelope = -64'sd4294967296;
      e = (envelope * 2786635) >>> 32;
      q = e >>> 16;
      f = e - q * 65536;
      g = 64'd1073741824;
      for (int k = 0; k < 16; k++)
        if (f[15-k]) g = (g * roots[k]) >> 30;
      if (-q >= 63) g = 0;
      else g = g >> (-q);
      y = (x * longint'(g)) >>> 30;
      r.sample_out = y[23:0];
      r.gain_db = envelope[32:8];
      pending.push_back(r);
    endfunction

    function void check_result(logic [55:0] data);
      result_t r;
      if (pending.size() == 0) begin
        $error("result 0x%0h arrived with no request outstanding", data);
        fails++;
        return;
      end
      r = pending.pop_front();
      if (data[23:0] !== r.sample_out) begin
        $error("sample_out expected %0d actual %0d", $signed(r.sample_out), $signed(data[23:0]));
        fails++;
      end
      if (data[48:24] !== r.gain_db) begin
        $error("gain_db expected %0d actual %0d", $signed(r.gain_db), $signed(data[48:24]));
        fails++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [23:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_THRESHOLD;
  logic [24:0] cfg_data = '0;

  gain_scoreboard sb = new();
  int src_idle = 0;
  int snk_idle = 0;
  int stall_left = 0;
  logic stall_go = 1'b0;
  logic stall_taken = 1'b0;
  int quiet_cycles = 0;
  int amp_shift = 0;

  log_domain_audio_compressor i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (stall_go && !stall_taken) begin
      stall_taken <= 1'b1;
      stall_left <= 399;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= 5000) begin
        $display("testbench NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_sample(logic [23:0] value);
    if ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= value;
    do @(posedge clk); while (!s_tready);
    sb.note_sample(value);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [24:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  function automatic logic [23:0] random_sample();
    logic [23:0] v;
    if ($urandom_range(99) < 5) amp_shift = $urandom_range(0, 23);
    case ($urandom_range(19))
      0: v = 24'h000000;
      1: v = 24'h7fffff;
      2: v = 24'h800000;
      default: begin
        v = 24'($urandom) >> amp_shift;
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) send_sample(random_sample());
  endtask

  initial begin
    logic [23:0] directed[$];
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    src_idle = 10;
    snk_idle = 63;
    directed = '{24'h000000, 24'h7fffff, 24'h800000, 24'hffffff, 24'h000001, 24'h000002,
                 24'h00003f, 24'h000040, 24'h000041, 24'h000080, 24'h0000ff, 24'h001000,
                 24'h400000, 24'h400001, 24'hc00000, 24'h7fffff, 24'h800001, 24'h000000,
                 24'h000000, 24'h555555, 24'haaaaaa, 24'h000000};
    foreach (directed[i]) send_sample(directed[i]);
    run_random(200);
    drain();

    write_reg(REG_THRESHOLD, 25'd0);
    write_reg(REG_RATIO, 25'd65536);
    write_reg(REG_ATTACK, 25'd16777216);
    write_reg(REG_RELEASE, 25'd16777216);
    stall_go = 1'b1;
    run_random(200);
    drain();

    src_idle = 63;
    snk_idle = 10;
    write_reg(REG_THRESHOLD, 25'(-9437184));
    write_reg(REG_RATIO, 25'd0);
    write_reg(REG_ATTACK, 25'd0);
    write_reg(REG_RELEASE, 25'd0);
    run_random(80);
    drain();

    write_reg(REG_RATIO, 25'h1ffffff);
    write_reg(REG_ATTACK, 25'h1ffffff);
    write_reg(REG_RELEASE, 25'd30000000);
    write_reg(REG_THRESHOLD, 25'd5000000);
    run_random(150);
    drain();

    src_idle = 0;
    snk_idle = 0;
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_THRESHOLD, 25'(-$signed($urandom_range(0, 9437184))));
      write_reg(REG_RATIO, 25'($urandom_range(0, 65536)));
      write_reg(REG_ATTACK, 25'($urandom_range(0, 1 << ($urandom_range(4, 24)))));
      write_reg(REG_RELEASE, 25'($urandom_range(0, 1 << ($urandom_range(4, 24)))));
      run_random(110);
      drain();
    end

    if (sb.fails == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
